>>> sv/mcpg_pkg.sv
// ---------------------------------------------------------------------------
// mcpg_pkg
// Shared constants, step codes and control-store contents for the
// midpoint circle pixel generator.
// ---------------------------------------------------------------------------
package mcpg_pkg;

    localparam int MAX_RADIUS = 63;

    localparam int COORD_W    = 13;
    localparam int RAD_W      = 6;
    localparam int OCT_W      = 7;
    localparam int DEC_W      = 10;
    localparam int STRIDE_W   = 14;
    localparam int BUF_W      = 27;
    localparam int IDX_W      = 32;
    localparam int SCALED_W   = OCT_W + STRIDE_W;
    localparam int CYS_W      = COORD_W + STRIDE_W;
    localparam int N_IDX      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_PIXELS = CFG_IDX_W'(1);

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1024);
    localparam logic [BUF_W-1:0]    BUF_RESET    = BUF_W'(786432);

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_SCALE,
        ST_BASE,
        ST_EMIT
    } t_step;

    // One control word per step.
    typedef struct packed {
        logic  wait_in;   // hold until a command beat is taken
        logic  ld_cmd;    // latch centre, radius, start decision
        logic  ld_scale;  // row products: cy*stride, r*stride
        logic  ld_base;   // base = cx + cy*stride
        logic  emit;      // hold until output register is free, then emit+advance
        logic  jmp_last;  // take alt when current point is the last one
        t_step nxt;
        t_step alt;
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '{wait_in: 1'b0, ld_cmd: 1'b0, ld_scale: 1'b0, ld_base: 1'b0,
              emit: 1'b0, jmp_last: 1'b0, nxt: ST_ACCEPT, alt: ST_ACCEPT};
        case (s)
            ST_ACCEPT: begin
                w.wait_in = 1'b1;
                w.ld_cmd  = 1'b1;
                w.nxt     = ST_SCALE;
            end
            ST_SCALE: begin
                w.ld_scale = 1'b1;
                w.nxt      = ST_BASE;
            end
            ST_BASE: begin
                w.ld_base = 1'b1;
                w.nxt     = ST_EMIT;
            end
            ST_EMIT: begin
                w.emit     = 1'b1;
                w.jmp_last = 1'b1;
                w.nxt      = ST_EMIT;
                w.alt      = ST_ACCEPT;
            end
            default: begin
                w.nxt = ST_ACCEPT;
            end
        endcase
        return w;
    endfunction

endpackage

>>> sv/midpoint_circle_pixel_generator.sv
// ---------------------------------------------------------------------------
// midpoint_circle_pixel_generator
// Bresenham circle outline over one octant; each point gives the eight
// mirrored linear framebuffer indices, an in-range mask and a last flag.
// ---------------------------------------------------------------------------
// A command (centre, radius) is taken when the block is idle. Setup follows
// in order (command latch, row products, base index), then one point beat
// per cycle while the output is not stalled. The point rate is set by the
// emit step of the sequencer, which forms one point and applies one
// decision update per cycle while the output register is free. The next
// command can be taken while the final point beat still waits in the output
// register. Row offsets are kept as running multiples of the line stride,
// so the point loop has no multiply.
module midpoint_circle_pixel_generator
    import mcpg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_W-1:0]    i_center_x,
    input  logic [COORD_W-1:0]    i_center_y,
    input  logic [RAD_W-1:0]      i_radius,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [IDX_W-1:0]      o_index_a,
    output logic [IDX_W-1:0]      o_index_b,
    output logic [IDX_W-1:0]      o_index_c,
    output logic [IDX_W-1:0]      o_index_d,
    output logic [IDX_W-1:0]      o_index_e,
    output logic [IDX_W-1:0]      o_index_f,
    output logic [IDX_W-1:0]      o_index_g,
    output logic [IDX_W-1:0]      o_index_h,
    output logic [N_IDX-1:0]      o_in_range_mask,
    output logic                  o_last_point,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_step                      r_step, n_step;
    t_uword                     w_uw;

    logic [STRIDE_W-1:0]        r_stride;
    logic [BUF_W-1:0]           r_buf;

    logic [COORD_W-1:0]         r_cx, r_cy;
    logic [OCT_W-1:0]           r_x, r_y;
    logic signed [DEC_W-1:0]    r_d;
    logic [SCALED_W-1:0]        r_xs, r_ys;
    logic [CYS_W-1:0]           r_cys;
    logic [IDX_W-1:0]           r_base;

    logic                       r_out_valid;
    logic [IDX_W-1:0]           r_idx [N_IDX];
    logic                       r_last;

    logic                       w_in_acc, w_out_free, w_emit_go, w_pt_last, w_dpos;
    logic [OCT_W-1:0]           w_r_in, w_r, w_x1, w_y1;
    logic signed [DEC_W-1:0]    w_d0, w_sx1, w_sy1, w_dinc;
    logic [IDX_W-1:0]           w_ex, w_ey, w_exs, w_eys;
    logic [IDX_W-1:0]           w_idx [N_IDX];
    logic [N_IDX-1:0]           w_mask;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_ACCEPT;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w_uw       = ucode(r_step);
        o_in_stall = !w_uw.wait_in;
        w_in_acc   = i_in_valid && w_uw.wait_in;
        w_out_free = !r_out_valid || !i_out_stall;
        w_emit_go  = w_uw.emit && w_out_free;
        n_step     = r_step;
        if ((!w_uw.wait_in || w_in_acc) && (!w_uw.emit || w_out_free)) begin
            n_step = (w_uw.jmp_last && w_pt_last) ? w_uw.alt : w_uw.nxt;
        end
    end

    // ---------------- datapath ----------------
    assign w_r_in = OCT_W'(i_radius);
    assign w_r    = (w_r_in > OCT_W'(MAX_RADIUS)) ? OCT_W'(MAX_RADIUS) : w_r_in;
    assign w_d0   = $signed(DEC_W'(3)) - $signed({{(DEC_W-OCT_W-1){1'b0}}, w_r, 1'b0});

    assign w_pt_last = !(r_y > r_x);
    assign w_dpos    = r_d > $signed(DEC_W'(0));
    assign w_x1      = r_x + OCT_W'(1);
    assign w_y1      = w_dpos ? (r_y - OCT_W'(1)) : r_y;
    assign w_sx1     = $signed(DEC_W'(w_x1));
    assign w_sy1     = $signed(DEC_W'(w_y1));
    assign w_dinc    = w_dpos ? (((w_sx1 - w_sy1) <<< 2) + $signed(DEC_W'(10)))
                              : ((w_sx1 <<< 2) + $signed(DEC_W'(6)));

    always_ff @(posedge i_clk) begin
        if (w_uw.ld_cmd && w_in_acc) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_x  <= '0;
            r_y  <= w_r;
            r_d  <= w_d0;
        end
        if (w_uw.ld_scale) begin
            r_xs  <= '0;
            r_ys  <= SCALED_W'(r_y) * SCALED_W'(r_stride);
            r_cys <= CYS_W'(r_cy) * CYS_W'(r_stride);
        end
        if (w_uw.ld_base) begin
            r_base <= IDX_W'(r_cx) + IDX_W'(r_cys);
        end
        if (w_emit_go && !w_pt_last) begin
            r_x  <= w_x1;
            r_xs <= r_xs + SCALED_W'(r_stride);
            r_d  <= r_d + w_dinc;
            if (w_dpos) begin
                r_y  <= w_y1;
                r_ys <= r_ys - SCALED_W'(r_stride);
            end
        end
    end

    // Mirrored indices: base +/- column offset +/- row offset, all mod 2^32.
    assign w_ex  = IDX_W'(r_x);
    assign w_ey  = IDX_W'(r_y);
    assign w_exs = IDX_W'(r_xs);
    assign w_eys = IDX_W'(r_ys);

    assign w_idx[0] = r_base + w_ex + w_eys;
    assign w_idx[1] = r_base - w_ex + w_eys;
    assign w_idx[2] = r_base + w_ex - w_eys;
    assign w_idx[3] = r_base - w_ex - w_eys;
    assign w_idx[4] = r_base + w_ey + w_exs;
    assign w_idx[5] = r_base - w_ey + w_exs;
    assign w_idx[6] = r_base + w_ey - w_exs;
    assign w_idx[7] = r_base - w_ey - w_exs;

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_go) begin
            for (int k = 0; k < N_IDX; k++) begin
                r_idx[k] <= w_idx[k];
            end
            r_last <= w_pt_last;
        end
    end

    always_comb begin
        for (int k = 0; k < N_IDX; k++) begin
            w_mask[k] = r_idx[k] < IDX_W'(r_buf);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_index_a       = r_idx[0];
    assign o_index_b       = r_idx[1];
    assign o_index_c       = r_idx[2];
    assign o_index_d       = r_idx[3];
    assign o_index_e       = r_idx[4];
    assign o_index_f       = r_idx[5];
    assign o_index_g       = r_idx[6];
    assign o_index_h       = r_idx[7];
    assign o_in_range_mask = w_mask;
    assign o_last_point    = r_last;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
            r_buf    <= BUF_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_LINE_STRIDE) begin
                r_stride <= i_cfg_data[STRIDE_W-1:0];
            end else if (i_cfg_index == REG_BUFFER_PIXELS) begin
                r_buf <= i_cfg_data[BUF_W-1:0];
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Running row offset must track y * stride through the whole point loop.
    a_ys_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_EMIT) |-> (r_ys == SCALED_W'(r_y) * SCALED_W'(r_stride)))
        else $error("row offset out of step with y");

    a_xs_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_EMIT) |-> (r_xs == SCALED_W'(r_x) * SCALED_W'(r_stride)))
        else $error("column offset out of step with x");

    // The walk never overshoots the octant boundary by more than one step.
    a_octant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_EMIT) |-> (r_x <= r_y + OCT_W'(1)))
        else $error("octant walk overshot");

    // Emitting the final point returns the sequencer to command accept.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit_go && w_pt_last) |=> (r_step == ST_ACCEPT && r_out_valid && r_last))
        else $error("sequencer did not finish after last point");
`endif

endmodule
